>>> hw/rtl/bmmd_pkg.sv
// Shared types and constants for the banked memory map decoder.
`default_nettype none

package bmmd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_MACHINE_VARIANT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SELECT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_ROM_IN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_COMMAND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_PAGE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE        = 3'd5;

    localparam logic [2:0] BANK_FLAT     = 3'd0;
    localparam logic [2:0] BANK_UP_32K   = 3'd2;
    localparam logic [2:0] BANK_UP_64K   = 3'd3;
    localparam logic [2:0] BANK_LO_64K   = 3'd6;
    localparam logic [2:0] BANK_LO_96K   = 3'd7;

    localparam logic [1:0] MAP_BASE      = 2'd0;
    localparam logic [1:0] MAP_LOW_RAM   = 2'd1;
    localparam logic [1:0] MAP_HIGH_IO   = 2'd2;
    localparam logic [1:0] MAP_ALL_RAM   = 2'd3;

    localparam logic [15:0] KBD_BASE    = 16'h3800;
    localparam logic [15:0] VID_BASE    = 16'h3C00;
    localparam logic [15:0] RAM_BASE    = 16'h4000;
    localparam logic [15:0] PRN_BASE    = 16'h37E8;
    localparam logic [15:0] HI_KBD_BASE = 16'hF400;
    localparam logic [15:0] HI_VID_BASE = 16'hF800;
    localparam logic [13:0] ROM_LIMIT   = 14'h3800;
    localparam logic [7:0]  OPEN_BUS    = 8'hFF;

    typedef enum logic [2:0] {
        TGT_NONE  = 3'd0,
        TGT_RAM   = 3'd1,
        TGT_ROM   = 3'd2,
        TGT_VIDEO = 3'd3,
        TGT_KBD   = 3'd4,
        TGT_PRN   = 3'd5
    } t_target;

    typedef struct packed {
        logic        machine_variant;
        logic [1:0]  map_select;
        logic        boot_rom_in;
        logic [2:0]  bank_command;
        logic        video_page;
        logic [13:0] rom_size;
    } t_cfg;

    typedef struct packed {
        logic        action;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        t_target     target;
        logic [16:0] location;
        logic [7:0]  store_data;
        logic [7:0]  open_bus_byte;
        logic        bank_code_bad;
    } t_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/bmmd_if.sv
// Valid/ready channel interfaces for access words and decoded result words.
`default_nettype none

interface bmmd_req_if;
    logic            valid;
    logic            ready;
    bmmd_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bmmd_rsp_if;
    logic            valid;
    logic            ready;
    bmmd_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bmmd_cfg_regs.sv
// Configuration register file with a plain indexed write port.
`default_nettype none

module bmmd_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bmmd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bmmd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output bmmd_pkg::t_cfg                         o_cfg
);
    import bmmd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.machine_variant <= 1'b0;
            r_cfg.map_select      <= MAP_BASE;
            r_cfg.boot_rom_in     <= 1'b0;
            r_cfg.bank_command    <= BANK_FLAT;
            r_cfg.video_page      <= 1'b0;
            r_cfg.rom_size        <= ROM_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MACHINE_VARIANT: r_cfg.machine_variant <= i_cfg_wdata[0];
                CFG_MAP_SELECT:      r_cfg.map_select      <= i_cfg_wdata[1:0];
                CFG_BOOT_ROM_IN:     r_cfg.boot_rom_in     <= i_cfg_wdata[0];
                CFG_BANK_COMMAND:    r_cfg.bank_command    <= i_cfg_wdata[2:0];
                CFG_VIDEO_PAGE:      r_cfg.video_page      <= i_cfg_wdata[0];
                CFG_ROM_SIZE:        r_cfg.rom_size        <= i_cfg_wdata[13:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/bmmd_decode.sv
// Combinational address decode of one access word under the current map.
`default_nettype none

module bmmd_decode (
    input  wire bmmd_pkg::t_cfg  i_cfg,
    input  wire bmmd_pkg::t_req  i_req,
    output bmmd_pkg::t_rsp       o_rsp
);
    import bmmd_pkg::*;

    logic [15:0] addr;
    logic        writing;
    logic [16:0] offset;
    logic        bad;
    logic [16:0] ram_loc;
    logic [16:0] vid_loc;
    logic [16:0] hi_vid_loc;
    logic [13:0] romlim;
    logic        below_rom;
    logic        is_prn;
    t_target     tgt;
    logic [16:0] loc;

    assign addr    = i_req.cpu_address;
    assign writing = i_req.action;

    always_comb begin
        bad = 1'b0;
        unique case (i_cfg.bank_command)
            BANK_FLAT:   offset = 17'h00000;
            BANK_UP_32K: offset = addr[15] ? 17'h08000 : 17'h00000;
            BANK_UP_64K: offset = addr[15] ? 17'h10000 : 17'h00000;
            BANK_LO_64K: offset = addr[15] ? 17'h00000 : 17'h10000;
            BANK_LO_96K: offset = addr[15] ? 17'h00000 : 17'h18000;
            default: begin
                offset = 17'h00000;
                bad    = 1'b1;
            end
        endcase
    end

    assign ram_loc    = {1'b0, addr} + offset;
    assign vid_loc    = {6'd0, i_cfg.video_page, addr[9:0]};
    assign hi_vid_loc = {6'd0, addr[10:0]};
    assign romlim     = (i_cfg.rom_size > ROM_LIMIT) ? ROM_LIMIT : i_cfg.rom_size;
    assign below_rom  = (addr < {2'b00, romlim});
    assign is_prn     = (addr[15:1] == PRN_BASE[15:1]);

    always_comb begin
        tgt = TGT_NONE;
        loc = {1'b0, addr};
        priority if (i_cfg.map_select == MAP_ALL_RAM) begin
            tgt = TGT_RAM;
        end else if (i_cfg.map_select == MAP_HIGH_IO) begin
            priority if (addr < HI_KBD_BASE) begin
                tgt = TGT_RAM;
            end else if (addr >= HI_VID_BASE) begin
                tgt = TGT_VIDEO;
                loc = hi_vid_loc;
            end else begin
                tgt = writing ? TGT_NONE : TGT_KBD;
            end
        end else if (writing) begin
            priority if (addr >= RAM_BASE ||
                         (i_cfg.map_select == MAP_LOW_RAM && addr < KBD_BASE)) begin
                tgt = TGT_RAM;
            end else if (addr >= VID_BASE) begin
                tgt = TGT_VIDEO;
                loc = vid_loc;
            end else begin
                tgt = TGT_NONE;
            end
        end else if (i_cfg.map_select == MAP_BASE && !i_cfg.machine_variant) begin
            priority if (addr >= RAM_BASE) begin
                tgt = TGT_RAM;
            end else if (is_prn) begin
                tgt = TGT_PRN;
            end else if (below_rom) begin
                tgt = TGT_ROM;
            end else if (addr >= VID_BASE) begin
                tgt = TGT_VIDEO;
                loc = vid_loc;
            end else if (addr >= KBD_BASE) begin
                tgt = TGT_KBD;
            end else begin
                tgt = TGT_NONE;
            end
        end else begin
            priority if (i_cfg.machine_variant && i_cfg.boot_rom_in && below_rom) begin
                tgt = TGT_ROM;
            end else if (addr >= RAM_BASE || addr < KBD_BASE) begin
                tgt = TGT_RAM;
            end else if (addr >= VID_BASE) begin
                tgt = TGT_VIDEO;
                loc = vid_loc;
            end else begin
                tgt = TGT_KBD;
            end
        end
        if (tgt == TGT_RAM) begin
            loc = ram_loc;
        end
    end

    always_comb begin
        o_rsp.target        = tgt;
        o_rsp.location      = loc;
        o_rsp.store_data    = writing ? i_req.write_data : 8'h00;
        o_rsp.open_bus_byte = (!writing && tgt == TGT_NONE) ? OPEN_BUS : 8'h00;
        o_rsp.bank_code_bad = bad;
    end

endmodule

`default_nettype wire

>>> hw/rtl/banked_memory_map_decoder.sv
// Top level: input register, address decode and result register.
//
//   Channel   Direction  Word                                       Handshake
//   i_req     in         action, cpu_address, write_data            valid/ready
//   o_rsp     out        target, location, store_data, open_bus_byte,
//                        bank_code_bad                              valid/ready
//   i_cfg_*   in         register index and write data              write enable
//
// One word per clock is taken unless stalled; each goes input then result register.
// The path between the input register and the result register is one decode pass.
// A stalled result holds in the result register while one more word waits in the
// input register; ready drops only when both are full and o_rsp.ready is low.
// Reset clears both stage valid bits and sets the configuration to its defaults.
`default_nettype none

module banked_memory_map_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    bmmd_req_if.sink                               i_req,
    bmmd_rsp_if.source                             o_rsp,
    input  wire logic                              i_cfg_we,
    input  wire logic [bmmd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bmmd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import bmmd_pkg::*;

    t_cfg cfg;
    t_req r_in_data;
    logic r_in_valid;
    t_rsp dec_rsp;
    t_rsp r_out_data;
    logic r_out_valid;
    logic advance;

    bmmd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bmmd_decode u_decode (
        .i_cfg (cfg),
        .i_req (r_in_data),
        .o_rsp (dec_rsp)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_data <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= dec_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("Decoded word was lost on its way to the result register.");

    a_open_bus_unmapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.open_bus_byte != 8'h00) |->
            (r_out_data.target == TGT_NONE && r_out_data.store_data == 8'h00))
        else $error("Open-bus byte set on a mapped access or a write.");

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.target == TGT_NONE || r_out_data.target == TGT_RAM ||
                         r_out_data.target == TGT_ROM || r_out_data.target == TGT_VIDEO ||
                         r_out_data.target == TGT_KBD || r_out_data.target == TGT_PRN))
        else $error("Result word carries an undefined target code.");

    a_bank_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_data.bank_code_bad == !(cfg.bank_command == BANK_FLAT ||
            cfg.bank_command == BANK_UP_32K || cfg.bank_command == BANK_UP_64K ||
            cfg.bank_command == BANK_LO_64K || cfg.bank_command == BANK_LO_96K)))
        else $error("Bank code flag disagrees with the configured bank command.");
`endif

endmodule

`default_nettype wire
